FILE: design/cms_pkg.sv
`timescale 1ns / 1ps

package cms_pkg;

  localparam int ROWS        = 3;
  localparam int COLUMN_BITS = 17;

  localparam logic [31:0] MIX2     = 32'd2246822519;
  localparam logic [31:0] MIX3     = 32'd3266489917;
  localparam logic [31:0] MIX4     = 32'd668265263;
  localparam logic [31:0] MIX5     = 32'd374761393;
  localparam logic [31:0] ID_BYTES = 32'd12;

  // per-row seeds, row 0 in the low word
  localparam logic [2:0][31:0] ROW_SEED = {32'd1151, 32'd5197, 32'd181};

  typedef logic [31:0]                              word_t;
  typedef logic signed [31:0]                       est_t;
  typedef logic [COLUMN_BITS-1:0]                   col_addr_t;
  typedef logic [ROWS-1:0][COLUMN_BITS-1:0]         col_vec_t;
  typedef logic [2:0][31:0]                         flow_words_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  function automatic word_t rotl17(input word_t x);
    return {x[14:0], x[31:15]};
  endfunction

  function automatic word_t hash_init(input word_t seed);
    return seed + ID_BYTES + MIX5;
  endfunction

endpackage

FILE: design/count_min_sketch_query.sv
// Load word: written to its row memory at acceptance, no result; a new word is taken
// whenever the block is idle. Query word: hash sequencer, registered row memory read,
// minimum into the result register, then the output register, which waits while an
// older result is not taken; the next word is accepted once the result is in it.
// Reset clears control only; counter memories hold no reset value until loaded.
`timescale 1ns / 1ps

module count_min_sketch_query import cms_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,  // src_addr, dst_addr, src_port, dst_port,
                                  // row_sel, column, count_in, zero pad
  input  logic         in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata  // estimate
);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_READ, S_DONE} state_t;

  localparam est_t EST_MAX = 32'sh7fffffff;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  est_t   out_tdata_r, out_tdata_nxt;
  est_t   result_r, result_nxt;

  logic        in_fire;
  logic        query_fire;
  logic        load_fire;
  logic [1:0]  in_row_sel;
  logic [16:0] in_column;
  word_t       in_count;
  flow_words_t flow_words;
  logic        col_ok;
  col_addr_t   load_addr;
  logic        hash_done;
  col_vec_t    cols;
  est_t        rd [ROWS];
  est_t        row_min;

  assign flow_words = {in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]};
  assign in_row_sel = in_tdata[97:96];
  assign in_column  = in_tdata[114:98];
  assign in_count   = in_tdata[146:115];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign query_fire = in_fire && (in_tuser == OP_QUERY);
  assign load_fire  = in_fire && (in_tuser == OP_LOAD);
  assign col_ok     = ((32'(in_column) >> COLUMN_BITS) == 32'd0);
  assign load_addr  = COLUMN_BITS'(in_column);

  cms_hash u_hash (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (query_fire),
    .flow_words (flow_words),
    .done       (hash_done),
    .cols       (cols)
  );

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    cms_row_ram #(
      .ADDR_W (COLUMN_BITS),
      .DATA_W (32)
    ) u_ram (
      .clk   (clk),
      .we    (load_fire && col_ok && (in_row_sel == 2'(r))),
      .waddr (load_addr),
      .wdata (in_count),
      .re    (hash_done),
      .raddr (cols[r]),
      .rdata (rd[r])
    );
  end

  always_comb begin
    row_min = EST_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (rd[r] < row_min) begin
        row_min = rd[r];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    result_nxt     = result_r;
    unique case (state_r)
      S_IDLE: begin
        if (query_fire) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // row data registered by the memories on entry to this state
        result_nxt = row_min;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = result_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    result_r    <= result_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_query_to_hash: assert property (@(posedge clk) disable iff (!rst_n)
    query_fire |=> state_r == S_HASH)
    else $error("query word did not start hashing");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> state_r == S_IDLE)
    else $error("load word left idle");

  a_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> state_r == S_HASH)
    else $error("hash finished outside a query");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result word without a finished query");

endmodule

FILE: design/cms_row_ram.sv
`timescale 1ns / 1ps

module cms_row_ram #(
  parameter int ADDR_W = 17,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/cms_hash.sv
`timescale 1ns / 1ps

module cms_hash import cms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  flow_words_t flow_words,
  output logic        done,
  output col_vec_t    cols
);

  typedef enum logic [3:0] {
    H_IDLE, H_M0, H_A0, H_B0, H_A1, H_B1, H_A2, H_B2, H_F1, H_F2, H_DONE
  } hstate_t;

  hstate_t     state_r, state_nxt;
  flow_words_t w_r, w_nxt;
  word_t       t_r, t_nxt;
  word_t       h_r   [ROWS];
  word_t       h_nxt [ROWS];

  word_t t_mul_in;
  word_t t_prod;
  word_t mix_k;
  logic  do_rot;
  logic  do_mul;
  logic  do_init;

  always_comb begin
    case (state_r)
      H_A0:    t_mul_in = w_r[1];
      H_A1:    t_mul_in = w_r[2];
      default: t_mul_in = w_r[0];
    endcase
    case (state_r)
      H_F1:    mix_k = MIX2;
      H_F2:    mix_k = MIX3;
      default: mix_k = MIX4;
    endcase
    t_prod  = t_mul_in * MIX3;
    do_init = (state_r == H_IDLE) && start;
    do_rot  = (state_r == H_A0) || (state_r == H_A1) || (state_r == H_A2);
    do_mul  = (state_r == H_B0) || (state_r == H_B1) || (state_r == H_B2) ||
              (state_r == H_F1) || (state_r == H_F2);
  end

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    t_nxt     = t_r;
    unique case (state_r)
      H_IDLE: begin
        if (start) begin
          w_nxt     = flow_words;
          state_nxt = H_M0;
        end
      end
      H_M0: begin
        t_nxt     = t_prod;
        state_nxt = H_A0;
      end
      H_A0: begin
        t_nxt     = t_prod;
        state_nxt = H_B0;
      end
      H_B0: state_nxt = H_A1;
      H_A1: begin
        t_nxt     = t_prod;
        state_nxt = H_B1;
      end
      H_B1:   state_nxt = H_A2;
      H_A2:   state_nxt = H_B2;
      H_B2:   state_nxt = H_F1;
      H_F1:   state_nxt = H_F2;
      H_F2:   state_nxt = H_DONE;
      H_DONE: state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  // one multiplier per row lane; the avalanche xor-shift rides in front of it
  always_comb begin
    word_t mix_in;
    for (int r = 0; r < ROWS; r++) begin
      case (state_r)
        H_F1:    mix_in = h_r[r] ^ (h_r[r] >> 15);
        H_F2:    mix_in = h_r[r] ^ (h_r[r] >> 13);
        default: mix_in = h_r[r];
      endcase
      if (do_init) begin
        h_nxt[r] = hash_init(ROW_SEED[r]);
      end else if (do_rot) begin
        h_nxt[r] = rotl17(h_r[r] + t_r);
      end else if (do_mul) begin
        h_nxt[r] = mix_in * mix_k;
      end else begin
        h_nxt[r] = h_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    t_r <= t_nxt;
    for (int r = 0; r < ROWS; r++) begin
      h_r[r] <= h_nxt[r];
    end
  end

  // last xor-shift folds straight into the column address
  always_comb begin
    word_t fin;
    for (int r = 0; r < ROWS; r++) begin
      fin     = h_r[r] ^ (h_r[r] >> 16);
      cols[r] = fin[COLUMN_BITS-1:0];
    end
  end

  assign done = (state_r == H_DONE);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && (state_r == H_IDLE) |=> state_r == H_M0)
    else $error("hash start not taken");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("hash done longer than one cycle");

  a_done_after_f2: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(state_r == H_F2))
    else $error("hash done out of sequence");

endmodule
